FILE: sv/pmmh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pmmh_pkg;

	// heap geometry
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	// child index width: 2*pos+2 must not wrap
	localparam int IDX_W    = ADDR_W + 2;

	// field widths
	localparam int KIND_W      = 2;
	localparam int DOC_W       = 32;
	localparam int BYTE_W      = 32;
	localparam int TAG_W       = 16;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 7;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT  = 2'd0,
		KIND_REPLACE = 2'd1,
		KIND_POP     = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [DOC_W-1:0]  doc;
		logic [BYTE_W-1:0] byt;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_POP_RD,
		ST_POP_LD,
		ST_DN_RD,
		ST_DN_CH,
		ST_DN_CMP,
		ST_WRITE,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

FILE: sv/pmmh_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

// operation channel
interface pmmh_op_if;
	import pmmh_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [DOC_W-1:0]  key_doc;
	logic [BYTE_W-1:0] key_byte;
	logic [TAG_W-1:0]  src_tag;

	modport source (output valid, kind, key_doc, key_byte, src_tag, input ready);
	modport sink (input valid, kind, key_doc, key_byte, src_tag, output ready);
endinterface

// result channel
interface pmmh_res_if;
	import pmmh_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   top_valid;
	logic [DOC_W-1:0]       top_doc;
	logic [BYTE_W-1:0]      top_byte;
	logic [TAG_W-1:0]       top_tag;
	logic [COUNT_OUT_W-1:0] entry_count;
	logic [STATUS_W-1:0]    status;

	modport source (output valid, top_valid, top_doc, top_byte, top_tag, entry_count, status,
		input ready);
	modport sink (input valid, top_valid, top_doc, top_byte, top_tag, entry_count, status,
		output ready);
endinterface

`default_nettype wire

FILE: sv/pmmh_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pmmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

FILE: sv/pmmh_key_cmp.sv
`timescale 1ns / 1ps
`default_nettype none

module pmmh_key_cmp (
	input  wire pmmh_pkg::entry_t a,
	input  wire pmmh_pkg::entry_t b,
	output logic                  lt
);

	import pmmh_pkg::*;

	// document id first, byte offset breaks ties, tag ignored
	always_comb begin
		if (a.doc != b.doc) begin
			lt = a.doc < b.doc;
		end else begin
			lt = a.byt < b.byt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/posting_merge_min_heap_core.sv
`timescale 1ns / 1ps
`default_nettype none

// one item at a time: an error, an unused kind or a pop of the last entry goes straight
// to the result, an insert sifts up through the parent compare state, and replace or pop
// sift down through the child read, child choice and compare states, all sharing the
// single key comparator and the registered heap ram read
// the next item is taken once the result sits in the output register
// arst_n clears the entry count and the control state; heap ram is not cleared

module posting_merge_min_heap_core (
	input wire logic clk,
	input wire logic arst_n,
	pmmh_op_if.sink  op,
	pmmh_res_if.source res
);

	import pmmh_pkg::*;

	// sequencer and control state
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	status_t           status_q;
	logic              res_valid_q;

	// moving entry, its slot, chosen child
	entry_t            cur_q;
	logic [ADDR_W-1:0] pos_q;
	entry_t            pick_q;
	logic [ADDR_W-1:0] pick_idx_q;
	// shadow copy of slot zero
	entry_t            root_q;

	// ram ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	entry_t            ram_wdata;
	logic [ADDR_W-1:0] raddr_a, raddr_b;
	entry_t            rd_a, rd_b;

	// shared comparator
	entry_t cmp_a, cmp_b;
	logic   cmp_lt;

	logic acc, is_full, is_empty, res_free, res_load;

	// heap index arithmetic
	logic [ADDR_W-1:0] par, gpar;
	logic [IDX_W-1:0]  count_ext;
	logic [IDX_W-1:0]  left_ext, right_ext, pleft_ext, pright_ext;
	logic              left_has, right_has, pleft_has;

	assign acc      = op.valid && op.ready;
	assign is_full  = count_q >= CNT_W'(CAPACITY);
	assign is_empty = count_q == '0;
	assign res_free = !res_valid_q || res.ready;
	assign res_load = (state_q == ST_FIN) && res_free;

	assign par        = (pos_q - ADDR_W'(1)) >> 1;
	assign gpar       = (par - ADDR_W'(1)) >> 1;
	assign count_ext  = IDX_W'(count_q);
	assign left_ext   = IDX_W'({pos_q, 1'b1});
	assign right_ext  = left_ext + IDX_W'(1);
	assign pleft_ext  = IDX_W'({pick_idx_q, 1'b1});
	assign pright_ext = pleft_ext + IDX_W'(1);
	assign left_has   = left_ext < count_ext;
	assign right_has  = right_ext < count_ext;
	assign pleft_has  = pleft_ext < count_ext;

	pmmh_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	pmmh_key_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (cmp_lt)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (op.valid) begin
					case (op.kind)
						KIND_INSERT:  state_d = is_full ? ST_FIN :
							(is_empty ? ST_WRITE : ST_UP_RD);
						KIND_REPLACE: state_d = is_empty ? ST_FIN : ST_DN_RD;
						// popping the only entry leaves nothing to sift
						KIND_POP:     state_d = (is_empty || count_q == CNT_W'(1)) ?
							ST_FIN : ST_POP_RD;
						default:      state_d = ST_FIN;
					endcase
				end
			end
			ST_UP_RD:  state_d = ST_UP_CMP;
			ST_UP_CMP: begin
				if (cmp_lt) begin
					state_d = (par == '0) ? ST_WRITE : ST_UP_CMP;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_POP_RD: state_d = ST_POP_LD;
			ST_POP_LD: state_d = ST_DN_RD;
			ST_DN_RD:  state_d = left_has ? ST_DN_CH : ST_FIN;
			ST_DN_CH:  state_d = ST_DN_CMP;
			ST_DN_CMP: begin
				if (cmp_lt) begin
					// children of the new slot already read when it has any
					state_d = pleft_has ? ST_DN_CH : ST_DN_RD;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_WRITE:  state_d = ST_FIN;
			ST_FIN:    state_d = res_free ? ST_IDLE : ST_FIN;
			default:   state_d = ST_IDLE;
		endcase
	end

	// ram and comparator steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = cur_q;
		raddr_a   = pos_q;
		raddr_b   = pos_q;
		cmp_a     = cur_q;
		cmp_b     = rd_a;
		case (state_q)
			ST_UP_RD: begin
				raddr_a = par;
			end
			ST_UP_CMP: begin
				// parent moves down into the hole, or the entry settles here
				ram_we    = 1'b1;
				ram_wdata = cmp_lt ? rd_a : cur_q;
				raddr_a   = gpar;
			end
			ST_POP_RD: begin
				raddr_a = pos_q;
			end
			ST_DN_RD: begin
				ram_we  = !left_has;
				raddr_a = ADDR_W'(left_ext);
				raddr_b = ADDR_W'(right_ext);
			end
			ST_DN_CH: begin
				cmp_a = rd_a;
				cmp_b = rd_b;
			end
			ST_DN_CMP: begin
				cmp_a     = pick_q;
				cmp_b     = cur_q;
				ram_we    = 1'b1;
				ram_wdata = cmp_lt ? pick_q : cur_q;
				raddr_a   = ADDR_W'(pleft_ext);
				raddr_b   = ADDR_W'(pright_ext);
			end
			ST_WRITE: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign op.ready = state_q == ST_IDLE;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (acc && op.kind == KIND_INSERT && !is_full) begin
				count_q <= count_q + CNT_W'(1);
			end else if (acc && op.kind == KIND_POP && !is_empty) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q <= STATUS_OK;
			case (op.kind)
				KIND_INSERT: begin
					if (is_full) begin
						status_q <= STATUS_FULL;
					end
					cur_q <= '{doc: op.key_doc, byt: op.key_byte, tag: op.src_tag};
					pos_q <= ADDR_W'(count_q);
				end
				KIND_REPLACE: begin
					if (is_empty) begin
						status_q <= STATUS_EMPTY;
					end
					// root keeps its tag
					cur_q <= '{doc: op.key_doc, byt: op.key_byte, tag: root_q.tag};
					pos_q <= '0;
				end
				KIND_POP: begin
					if (is_empty) begin
						status_q <= STATUS_EMPTY;
					end
					pos_q <= ADDR_W'(count_q - CNT_W'(1));
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
		case (state_q)
			ST_UP_CMP: begin
				if (cmp_lt) begin
					pos_q <= par;
				end
			end
			ST_POP_LD: begin
				cur_q <= rd_a;
				pos_q <= '0;
			end
			ST_DN_CH: begin
				// lesser child, right one on a tie, left one when it is the only one
				if (cmp_lt || !right_has) begin
					pick_q     <= rd_a;
					pick_idx_q <= ADDR_W'(left_ext);
				end else begin
					pick_q     <= rd_b;
					pick_idx_q <= ADDR_W'(right_ext);
				end
			end
			ST_DN_CMP: begin
				if (cmp_lt) begin
					pos_q <= pick_idx_q;
				end
			end
			default: begin
				pick_q <= pick_q;
			end
		endcase
		if (ram_we && ram_waddr == '0) begin
			root_q <= ram_wdata;
		end
		if (res_load) begin
			res.top_valid   <= !is_empty;
			res.top_doc     <= is_empty ? '0 : root_q.doc;
			res.top_byte    <= is_empty ? '0 : root_q.byt;
			res.top_tag     <= is_empty ? '0 : root_q.tag;
			res.entry_count <= COUNT_OUT_W'(count_q);
			res.status      <= status_q;
		end
	end

	assign res.valid = res_valid_q;

	// entry count stays within the heap
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// accepted insert with room grows the heap by one
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && op.kind == KIND_INSERT && !is_full) |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the heap");

	// heap ram is never written while waiting for an item
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("ram write while idle");

	// reported validity follows the entry count
	a_top_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (res.top_valid == (count_q != '0)))
		else $error("top valid disagrees with count");

endmodule

`default_nettype wire

FILE: dv/posting_merge_min_heap_core_tb.sv
`timescale 1ns / 1ps

module posting_merge_min_heap_core_tb;
	import pmmh_pkg::*;

	// the two-bit kind field has one code that the block leaves without effect
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	// cycles to let pass after the last result
	localparam int SETTLE_CYCLES = 40;
	// length of the long receiver hold-off
	localparam int HOLD_CYCLES = 300;

	// what the block should show after one operation
	typedef struct {
		logic                   top_valid;
		logic [DOC_W-1:0]       top_doc;
		logic [BYTE_W-1:0]      top_byte;
		logic [TAG_W-1:0]       top_tag;
		logic [COUNT_OUT_W-1:0] entry_count;
		status_t                status;
	} heap_view_t;

	logic clk = 1'b0;
	logic arst_n;

	pmmh_op_if  op_ch ();
	pmmh_res_if res_ch ();

	posting_merge_min_heap_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_ch),
		.res    (res_ch)
	);

	always #5 clk = ~clk;

	// shadow heap, kept in step with every accepted item
	entry_t heap_slot [CAPACITY];
	int     heap_fill = 0;

	heap_view_t expected_views [$];
	int         fail_count = 0;

	// idling percentages for the current phase
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	// long hold-off of the result channel, run in its own process
	event hold_go;
	logic stall_hold = 1'b0;

	// ordering: document id first, byte offset breaks ties, tag takes no part
	function automatic bit slot_before(int a, int b);
		if (heap_slot[a].doc != heap_slot[b].doc)
			return heap_slot[a].doc < heap_slot[b].doc;
		return heap_slot[a].byt < heap_slot[b].byt;
	endfunction

	function automatic void swap_slots(int a, int b);
		entry_t keep;
		keep = heap_slot[a];
		heap_slot[a] = heap_slot[b];
		heap_slot[b] = keep;
	endfunction

	// walk the root down; on equal children the right one wins
	function automatic void sift_root_down();
		int pos;
		int left;
		int right;
		int pick;
		pos = 0;
		while (1'b1) begin
			left = 2 * pos + 1;
			right = left + 1;
			if (left >= heap_fill)
				return;
			if (right >= heap_fill) begin
				if (!slot_before(left, pos))
					return;
				pick = left;
			end else begin
				if (!slot_before(left, pos) && !slot_before(right, pos))
					return;
				pick = slot_before(left, right) ? left : right;
			end
			swap_slots(pos, pick);
			pos = pick;
		end
	endfunction

	// apply one operation to the shadow heap and queue the view it should produce
	function automatic void predict_heap_step(logic [KIND_W-1:0] kind, logic [DOC_W-1:0] doc,
			logic [BYTE_W-1:0] byt, logic [TAG_W-1:0] tag);
		heap_view_t view;
		int pos;
		int par;
		view.status = STATUS_OK;
		case (kind)
			KIND_INSERT: begin
				if (heap_fill >= CAPACITY) begin
					view.status = STATUS_FULL;
				end else begin
					pos = heap_fill;
					heap_slot[pos] = '{doc: doc, byt: byt, tag: tag};
					heap_fill++;
					// strictly less than the parent, so equal keys stay below
					while (pos > 0) begin
						par = (pos - 1) / 2;
						if (!slot_before(pos, par))
							break;
						swap_slots(pos, par);
						pos = par;
					end
				end
			end
			KIND_REPLACE: begin
				if (heap_fill == 0) begin
					view.status = STATUS_EMPTY;
				end else begin
					// keys are overwritten, the root keeps its tag
					heap_slot[0].doc = doc;
					heap_slot[0].byt = byt;
					sift_root_down();
				end
			end
			KIND_POP: begin
				if (heap_fill == 0) begin
					view.status = STATUS_EMPTY;
				end else begin
					heap_fill--;
					heap_slot[0] = heap_slot[heap_fill];
					sift_root_down();
				end
			end
			default: begin
				// unused code: heap untouched, root reported
			end
		endcase
		view.top_valid = (heap_fill > 0);
		if (heap_fill > 0) begin
			view.top_doc = heap_slot[0].doc;
			view.top_byte = heap_slot[0].byt;
			view.top_tag = heap_slot[0].tag;
		end else begin
			// an empty heap shows zeroes in the root fields
			view.top_doc = '0;
			view.top_byte = '0;
			view.top_tag = '0;
		end
		view.entry_count = heap_fill[COUNT_OUT_W-1:0];
		expected_views.push_back(view);
	endfunction

	// offer one item, with a random gap in front, and hold it until taken
	task automatic send_op(input logic [KIND_W-1:0] kind, input logic [DOC_W-1:0] doc,
			input logic [BYTE_W-1:0] byt, input logic [TAG_W-1:0] tag);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			op_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		op_ch.valid <= 1'b1;
		op_ch.kind <= kind;
		op_ch.key_doc <= doc;
		op_ch.key_byte <= byt;
		op_ch.src_tag <= tag;
		do
			@(posedge clk);
		while (!op_ch.ready);
		predict_heap_step(kind, doc, byt, tag);
	endtask

	// keys mostly from a narrow range so that ties are common, sometimes wide or extreme
	task automatic random_keys(output logic [DOC_W-1:0] doc, output logic [BYTE_W-1:0] byt);
		int pick;
		pick = $urandom_range(9);
		if (pick <= 5) begin
			doc = $urandom_range(7);
			byt = $urandom_range(3);
		end else if (pick <= 7) begin
			doc = $urandom;
			byt = $urandom;
		end else if (pick == 8) begin
			doc = $urandom_range(1) ? '1 : '0;
			byt = $urandom;
		end else begin
			doc = $urandom_range(1) ? '1 : '0;
			byt = $urandom_range(1) ? '1 : '0;
		end
	endtask

	// random operation; inserts lean heavier while the heap is shallow
	task automatic send_random_op();
		logic [KIND_W-1:0] kind;
		logic [DOC_W-1:0]  doc;
		logic [BYTE_W-1:0] byt;
		int                roll;
		int                insert_pct;
		insert_pct = (heap_fill < CAPACITY / 2) ? 58 : 42;
		roll = $urandom_range(99);
		if (roll < 4)
			kind = KIND_UNUSED;
		else if (roll < 4 + insert_pct)
			kind = KIND_INSERT;
		else if (roll < 4 + insert_pct + (96 - insert_pct) / 2)
			kind = KIND_REPLACE;
		else
			kind = KIND_POP;
		random_keys(doc, byt);
		send_op(kind, doc, byt, TAG_W'($urandom_range(16'hffff)));
	endtask

	// report one field that differs from the expectation
	function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			fail_count++;
		end
	endfunction

	task automatic check_view();
		heap_view_t want;
		if (expected_views.size() == 0) begin
			$error("result arrived with no operation outstanding");
			fail_count++;
			return;
		end
		want = expected_views.pop_front();
		compare_field("top_valid", want.top_valid, res_ch.top_valid);
		compare_field("top_doc", want.top_doc, res_ch.top_doc);
		compare_field("top_byte", want.top_byte, res_ch.top_byte);
		compare_field("top_tag", want.top_tag, res_ch.top_tag);
		compare_field("entry_count", want.entry_count, res_ch.entry_count);
		compare_field("status", want.status, res_ch.status);
	endtask

	// result side: check what is taken at this edge, then pick ready for the next
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			check_view();
		if (!arst_n || stall_hold)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// hold-off counter, started by the pressure test
	initial begin
		forever begin
			@(hold_go);
			stall_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			stall_hold <= 1'b0;
		end
	end

	// empty-heap errors, the unused code, tie rules and extreme keys
	task automatic test_directed();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_op(KIND_POP, '0, '0, '0);
		send_op(KIND_REPLACE, '1, '1, '1);
		send_op(KIND_UNUSED, '0, '0, '0);
		send_op(KIND_INSERT, 32'd5, 32'd5, 16'h1111);
		send_op(KIND_INSERT, 32'd7, 32'd0, 16'h2222);
		send_op(KIND_INSERT, 32'd7, 32'd0, 16'h3333);
		// both children equal: the right one must move up
		send_op(KIND_REPLACE, 32'd9, 32'd0, 16'hdead);
		// equal to the root: must not climb past it
		send_op(KIND_INSERT, 32'd7, 32'd0, 16'h4444);
		send_op(KIND_INSERT, 32'd0, 32'd0, 16'hffff);
		send_op(KIND_INSERT, '1, '1, 16'h0000);
		// same document, byte offset decides
		send_op(KIND_INSERT, 32'd5, '1, 16'haaaa);
		send_op(KIND_INSERT, 32'd5, 32'd0, 16'h5555);
		send_op(KIND_UNUSED, '1, '1, '1);
		send_op(KIND_REPLACE, '1, '1, 16'h0f0f);
		send_op(KIND_REPLACE, 32'd0, '1, 16'hf0f0);
		while (heap_fill > 0)
			send_op(KIND_POP, '0, '0, '0);
		send_op(KIND_POP, '1, '1, '1);
	endtask

	// fill to capacity, knock on the full heap, then drain with some replaces
	task automatic test_fill_and_drain();
		logic [DOC_W-1:0]  doc;
		logic [BYTE_W-1:0] byt;
		send_idle_pct = 30;
		recv_stall_pct = 30;
		while (heap_fill < CAPACITY) begin
			random_keys(doc, byt);
			send_op(KIND_INSERT, doc, byt, TAG_W'($urandom_range(16'hffff)));
		end
		send_op(KIND_INSERT, '0, '0, '0);
		send_op(KIND_INSERT, '1, '1, '1);
		while (heap_fill > 0) begin
			random_keys(doc, byt);
			send_op(($urandom_range(3) == 0) ? KIND_REPLACE : KIND_POP, doc, byt,
				TAG_W'($urandom_range(16'hffff)));
		end
		send_op(KIND_REPLACE, '0, '0, '0);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (count) send_random_op();
	endtask

	// results held back for a long stretch while items keep coming
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		-> hold_go;
		repeat (25) send_random_op();
	endtask

	// run limit, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("[posting_merge_min_heap_core] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		op_ch.valid = 1'b0;
		op_ch.kind = KIND_INSERT;
		op_ch.key_doc = '0;
		op_ch.key_byte = '0;
		op_ch.src_tag = '0;
		res_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_and_drain();
		test_random_traffic(0, 0, 100);
		test_random_traffic(60, 0, 100);
		test_random_traffic(0, 60, 100);
		test_random_traffic(30, 30, 100);
		test_backpressure();

		op_ch.valid <= 1'b0;
		while (expected_views.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[posting_merge_min_heap_core] OK");
		else
			$display("[posting_merge_min_heap_core] ERROR");
		$finish;
	end

endmodule
